FILE: hdl/dcb_pkg.sv
// Shared types, codes and segment table for the digit calculator with blink.
package dcb_pkg;

    localparam int ACC_WIDTH = 16;
    localparam int CNT_W     = $clog2(ACC_WIDTH);

    localparam logic [3:0] KEY_PLUS   = 4'd10;
    localparam logic [3:0] KEY_DIVIDE = 4'd13;
    localparam logic [3:0] KEY_EQUALS = 4'd14;
    localparam logic [3:0] KEY_CLEAR  = 4'd15;
    localparam logic [3:0] KEY_NINE   = 4'd9;

    localparam logic [3:0] SEG_DASH = 4'd10;
    localparam logic [3:0] SEG_E    = 4'd11;

    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic CFG_BLANK_AT     = 1'b0;
    localparam logic CFG_BLINK_PERIOD = 1'b1;

    localparam logic [15:0] BLANK_AT_RESET     = 16'd1000;
    localparam logic [15:0] BLINK_PERIOD_RESET = 16'd1500;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MODE_FIRST = 2'd0,
        MODE_OPER  = 2'd1,
        MODE_NEXT  = 2'd2,
        MODE_SHOW  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_CALC,
        CTL_EMIT
    } ctl_state_t;

    typedef enum logic [2:0] {
        ALU_IDLE,
        ALU_SERIAL,
        ALU_NEG_IN,
        ALU_DIV,
        ALU_NEG_OUT
    } alu_state_t;

    typedef struct packed {
        logic       start;
        logic       load;
        op_t        op;
        logic [3:0] digit;
    } alu_cmd_t;

    typedef struct packed {
        logic       busy;
        logic       in_range;
        logic [3:0] low_digit;
    } alu_stat_t;

    typedef struct packed {
        logic       upd;
        logic [7:0] seg;
    } blink_upd_t;

    function automatic logic [7:0] seg_of(input logic [3:0] idx);
        logic [7:0] s;
        case (idx)
            4'd0:    s = 8'h5F;
            4'd1:    s = 8'h06;
            4'd2:    s = 8'h9B;
            4'd3:    s = 8'h8F;
            4'd4:    s = 8'hC6;
            4'd5:    s = 8'hCD;
            4'd6:    s = 8'hDD;
            4'd7:    s = 8'h07;
            4'd8:    s = 8'hDF;
            4'd9:    s = 8'hCF;
            SEG_DASH: s = 8'h80;
            SEG_E:   s = 8'hD9;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

FILE: hdl/dcb_alu.sv
// Bit-serial accumulator unit: add, subtract, multiply and signed divide by one digit.
module dcb_alu
    import dcb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  alu_cmd_t  cmd,
    output alu_stat_t stat
);

    alu_state_t             state_reg, state_next;
    logic [ACC_WIDTH-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]       bit_idx_reg, bit_idx_next;
    logic [2:0]             carry_reg, carry_next;
    logic [2:0]             hist_reg, hist_next;
    logic [3:0]             rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    op_t                    op_reg, op_next;
    logic [3:0]             digit_reg, digit_next;

    logic       a0;
    logic       dbit;
    logic       last;
    logic [3:0] sum;
    logic [4:0] r5;
    logic       ge;
    logic [4:0] r5_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ALU_IDLE;
            acc_reg     <= '0;
            bit_idx_reg <= '0;
            carry_reg   <= '0;
            hist_reg    <= '0;
            rem_reg     <= '0;
            neg_reg     <= 1'b0;
            op_reg      <= OP_ADD;
            digit_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            bit_idx_reg <= bit_idx_next;
            carry_reg   <= carry_next;
            hist_reg    <= hist_next;
            rem_reg     <= rem_next;
            neg_reg     <= neg_next;
            op_reg      <= op_next;
            digit_reg   <= digit_next;
        end
    end

    always_comb
    begin
        a0     = acc_reg[0];
        last   = bit_idx_reg == CNT_W'(ACC_WIDTH - 1);
        dbit   = (bit_idx_reg < CNT_W'(4)) ? digit_reg[bit_idx_reg[1:0]] : 1'b0;
        r5     = {rem_reg, acc_reg[ACC_WIDTH-1]};
        ge     = r5 >= {1'b0, digit_reg};
        r5_sub = r5 - {1'b0, digit_reg};

        sum = '0;
        case (op_reg)
            OP_ADD:  sum = {3'b000, a0} + {3'b000, dbit} + {1'b0, carry_reg};
            OP_SUB:  sum = {3'b000, a0} + {3'b000, ~dbit} + {1'b0, carry_reg};
            default: sum = {3'b000, a0 & digit_reg[0]} + {3'b000, hist_reg[0] & digit_reg[1]}
                         + {3'b000, hist_reg[1] & digit_reg[2]}
                         + {3'b000, hist_reg[2] & digit_reg[3]} + {1'b0, carry_reg};
        endcase

        state_next   = state_reg;
        acc_next     = acc_reg;
        bit_idx_next = bit_idx_reg + CNT_W'(1);
        carry_next   = carry_reg;
        hist_next    = hist_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        op_next      = op_reg;
        digit_next   = digit_reg;

        unique case (state_reg)
            ALU_IDLE:
            begin
                bit_idx_next = '0;
                if (cmd.load)
                begin
                    acc_next = ACC_WIDTH'(cmd.digit);
                end
                else if (cmd.start)
                begin
                    op_next    = cmd.op;
                    digit_next = cmd.digit;
                    hist_next  = '0;
                    rem_next   = '0;
                    if (cmd.op == OP_DIV)
                    begin
                        neg_next   = acc_reg[ACC_WIDTH-1];
                        carry_next = 3'd1;
                        state_next = acc_reg[ACC_WIDTH-1] ? ALU_NEG_IN : ALU_DIV;
                    end
                    else
                    begin
                        carry_next = (cmd.op == OP_SUB) ? 3'd1 : 3'd0;
                        state_next = ALU_SERIAL;
                    end
                end
            end
            ALU_SERIAL:
            begin
                acc_next   = {sum[0], acc_reg[ACC_WIDTH-1:1]};
                carry_next = sum[3:1];
                hist_next  = {hist_reg[1:0], a0};
                if (last)
                begin
                    state_next = ALU_IDLE;
                end
            end
            ALU_NEG_IN, ALU_NEG_OUT:
            begin
                acc_next   = {~a0 ^ carry_reg[0], acc_reg[ACC_WIDTH-1:1]};
                carry_next = {2'b00, ~a0 & carry_reg[0]};
                if (last)
                begin
                    bit_idx_next = '0;
                    state_next   = (state_reg == ALU_NEG_IN) ? ALU_DIV : ALU_IDLE;
                end
            end
            ALU_DIV:
            begin
                acc_next = {acc_reg[ACC_WIDTH-2:0], ge};
                rem_next = ge ? r5_sub[3:0] : r5[3:0];
                if (last)
                begin
                    bit_idx_next = '0;
                    carry_next   = 3'd1;
                    state_next   = neg_reg ? ALU_NEG_OUT : ALU_IDLE;
                end
            end
            default:
            begin
                state_next = ALU_IDLE;
            end
        endcase
    end

    assign stat.busy      = state_reg != ALU_IDLE;
    assign stat.in_range  = (acc_reg[ACC_WIDTH-1:4] == '0) && (acc_reg[3:0] <= KEY_NINE);
    assign stat.low_digit = acc_reg[3:0];

endmodule

FILE: hdl/dcb_blink.sv
// Tick counter that blanks and restores the shown result.
module dcb_blink
    import dcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        tick,
    input  logic        restart,
    input  logic [7:0]  display_cur,
    input  logic [15:0] blank_at,
    input  logic [15:0] period,
    output blink_upd_t  upd
);

    logic [15:0] tick_count_reg, tick_count_next;
    logic [7:0]  saved_reg, saved_next;
    logic [15:0] cnt1;
    logic        eq_blank;
    logic        eq_period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            saved_reg      <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
            saved_reg      <= saved_next;
        end
    end

    always_comb
    begin
        cnt1            = tick_count_reg + 16'd1;
        eq_blank        = cnt1 == blank_at;
        eq_period       = cnt1 == period;
        tick_count_next = tick_count_reg;
        saved_next      = saved_reg;
        upd.upd         = 1'b0;
        upd.seg         = 8'h00;
        if (restart)
        begin
            tick_count_next = '0;
        end
        else if (tick)
        begin
            tick_count_next = eq_period ? 16'd0 : cnt1;
            if (eq_blank)
            begin
                saved_next = display_cur;
            end
            upd.upd = eq_blank | eq_period;
            if (eq_period)
            begin
                upd.seg = eq_blank ? display_cur : saved_reg;
            end
        end
    end

endmodule

FILE: hdl/digit_calculator_with_blink_unit.sv
// Top level: key and tick stream in, seven-segment byte stream out.
//
//   channel  dir  fields
//   s_axis   in   tuser[0] = cmd, tdata[3:0] = key
//   m_axis   out  tdata[7:0] = segments
//   cfg      in   addr 0 blank_at_tick, addr 1 blink_period
//
// Ticks, digits without arithmetic, operators, clear, equals: taken in IDLE, then sent from EMIT.
// Add, subtract, multiply: one bit per cycle through the serial ALU, in CALC between IDLE and EMIT.
// Divide: a negative accumulator is negated before and after the serial divide (sign passes).
// One item in flight; the next is taken while its result waits in the output register.
// Reset: rst_n async, active low; config resets to 1000 and 1500.
module digit_calculator_with_blink_unit
    import dcb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [3:0] key
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] segments
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata
);

    ctl_state_t  state_reg, state_next;
    mode_t       mode_reg, mode_next;
    op_t         pend_op_reg, pend_op_next;
    logic        err_reg, err_next;
    logic [7:0]  display_reg, display_next;
    logic [15:0] blank_at_reg;
    logic [15:0] period_reg;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;

    alu_cmd_t    alu_cmd;
    alu_stat_t   alu_stat;
    blink_upd_t  blink;
    logic        blink_tick;
    logic        blink_restart;

    logic        accept;
    logic [3:0]  key;
    logic        is_digit;
    logic        is_oper;
    logic        out_free;

    dcb_alu u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (alu_cmd),
        .stat (alu_stat)
    );

    dcb_blink u_blink (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (blink_tick),
        .restart    (blink_restart),
        .display_cur(display_reg),
        .blank_at   (blank_at_reg),
        .period     (period_reg),
        .upd        (blink)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_at_reg <= BLANK_AT_RESET;
            period_reg   <= BLINK_PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BLANK_AT:     blank_at_reg <= cfg_wdata;
                CFG_BLINK_PERIOD: period_reg   <= cfg_wdata;
                default:          period_reg   <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= CTL_IDLE;
            mode_reg     <= MODE_FIRST;
            pend_op_reg  <= OP_ADD;
            err_reg      <= 1'b0;
            display_reg  <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            pend_op_reg  <= pend_op_next;
            err_reg      <= err_next;
            display_reg  <= display_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign s_tready = state_reg == CTL_IDLE;
    assign accept   = s_tvalid && s_tready;
    assign key      = s_tdata[3:0];
    assign is_digit = key <= KEY_NINE;
    assign is_oper  = (key >= KEY_PLUS) && (key <= KEY_DIVIDE);
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        pend_op_next  = pend_op_reg;
        err_next      = err_reg;
        display_next  = display_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        alu_cmd.start = 1'b0;
        alu_cmd.load  = 1'b0;
        alu_cmd.op    = pend_op_reg;
        alu_cmd.digit = key;
        blink_tick    = 1'b0;
        blink_restart = 1'b0;

        unique case (state_reg)
            CTL_IDLE:
            begin
                if (accept)
                begin
                    state_next = CTL_EMIT;
                    if (s_tuser == CMD_TICK)
                    begin
                        if (mode_reg == MODE_SHOW)
                        begin
                            blink_tick = 1'b1;
                            if (blink.upd)
                            begin
                                display_next = blink.seg;
                            end
                        end
                    end
                    else if (mode_reg == MODE_FIRST)
                    begin
                        if (is_digit)
                        begin
                            display_next = seg_of(key);
                            err_next     = 1'b0;
                            alu_cmd.load = 1'b1;
                            mode_next    = MODE_OPER;
                        end
                    end
                    else if (mode_reg == MODE_NEXT && is_digit)
                    begin
                        display_next = seg_of(key);
                        mode_next    = MODE_OPER;
                        if (!err_reg)
                        begin
                            if (pend_op_reg == OP_DIV && key == 4'd0)
                            begin
                                err_next = 1'b1;
                            end
                            else
                            begin
                                alu_cmd.start = 1'b1;
                                state_next    = CTL_CALC;
                            end
                        end
                    end
                    else if (key == KEY_CLEAR)
                    begin
                        display_next = 8'h00;
                        mode_next    = MODE_FIRST;
                    end
                    else if (is_oper)
                    begin
                        display_next = seg_of(SEG_DASH);
                        pend_op_next = op_t'(2'(key - KEY_PLUS));
                        mode_next    = MODE_NEXT;
                    end
                    else if (key == KEY_EQUALS && mode_reg != MODE_SHOW)
                    begin
                        display_next  = (err_reg || !alu_stat.in_range)
                                      ? seg_of(SEG_E) : seg_of(alu_stat.low_digit);
                        mode_next     = MODE_SHOW;
                        blink_restart = 1'b1;
                    end
                end
            end
            CTL_CALC:
            begin
                if (!alu_stat.busy)
                begin
                    state_next = CTL_EMIT;
                end
            end
            CTL_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = display_reg;
                    state_next    = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_alu_idle_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CTL_IDLE) |-> !alu_stat.busy)
        else $error("ALU busy while controller idle");

    a_calc_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CTL_CALC) |-> (mode_reg == MODE_OPER))
        else $error("ALU running outside operator mode");

    a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == CTL_EMIT))
        else $error("result presented without an emit step");
`endif

endmodule

FILE: dv/digit_calculator_with_blink_unit_test.sv
// Self-checking testbench: key/tick stream in, predicted segment bytes checked on the output.
module digit_calculator_with_blink_unit_test;
    import dcb_pkg::*;

    localparam logic [3:0] KEY_MINUS   = 4'd11;
    localparam logic [3:0] KEY_TIMES   = 4'd12;
    localparam int         SETTLE_CYC  = 4 * ACC_WIDTH;
    localparam int         CYCLE_LIMIT = 4000000;

    localparam logic [7:0] SEG_TBL [0:11] = '{
        8'h5F, 8'h06, 8'h9B, 8'h8F, 8'hC6, 8'hCD,
        8'hDD, 8'h07, 8'hDF, 8'hCF, 8'h80, 8'hD9
    };

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'h00;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_we    = 1'b0;
    logic        cfg_addr  = 1'b0;
    logic [15:0] cfg_wdata = 16'h0000;

    // predicted block state
    mode_t       calc_mode   = MODE_FIRST;
    op_t         calc_op     = OP_ADD;
    logic        calc_err    = 1'b0;
    logic [15:0] calc_acc    = '0;
    logic [15:0] blink_cnt   = '0;
    logic [7:0]  blink_saved = '0;
    logic [7:0]  shown_seg   = '0;
    logic [15:0] cfg_blank_at = BLANK_AT_RESET;
    logic [15:0] cfg_period   = BLINK_PERIOD_RESET;

    logic [7:0]  seg_expect [$];
    logic [7:0]  seg_want;
    int          mismatches = 0;
    int          cycle_cnt  = 0;
    bit          no_idle    = 1'b0;

    digit_calculator_with_blink_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("digit_calculator_with_blink_unit: mismatch");
            $finish;
        end
    end

    function automatic void apply_digit(input logic [3:0] k);
        int acc_val;
        int quot;
        acc_val = $signed(calc_acc);
        case (calc_op)
            OP_ADD: calc_acc = calc_acc + {12'b0, k};
            OP_SUB: calc_acc = calc_acc - {12'b0, k};
            OP_MUL: calc_acc = calc_acc * {12'b0, k};
            default:
                if (k == 4'd0)
                    calc_err = 1'b1;
                else
                begin
                    quot = acc_val / int'(k);
                    calc_acc = 16'(quot);
                end
        endcase
    endfunction

    function automatic void enter_show();
        int acc_val;
        acc_val = $signed(calc_acc);
        if (calc_err || acc_val < 0 || acc_val > 9)
            shown_seg = SEG_TBL[SEG_E];
        else
            shown_seg = SEG_TBL[acc_val];
        calc_mode = MODE_SHOW;
        blink_cnt = '0;
    endfunction

    function automatic logic [7:0] next_segments(input logic cmd_bit, input logic [3:0] k);
        bit is_digit;
        bit is_op;
        is_digit = (k <= KEY_NINE);
        is_op    = (k >= KEY_PLUS && k <= KEY_DIVIDE);
        if (cmd_bit == CMD_TICK)
        begin
            if (calc_mode == MODE_SHOW)
            begin
                blink_cnt = blink_cnt + 16'd1;
                if (blink_cnt == cfg_blank_at)
                begin
                    blink_saved = shown_seg;
                    shown_seg   = 8'h00;
                end
                if (blink_cnt == cfg_period)
                begin
                    blink_cnt = '0;
                    shown_seg = blink_saved;
                end
            end
        end
        else
        begin
            case (calc_mode)
                MODE_FIRST:
                    if (is_digit)
                    begin
                        shown_seg = SEG_TBL[k];
                        calc_err  = 1'b0;
                        calc_acc  = {12'b0, k};
                        calc_mode = MODE_OPER;
                    end
                MODE_OPER, MODE_NEXT:
                    if (calc_mode == MODE_NEXT && is_digit)
                    begin
                        shown_seg = SEG_TBL[k];
                        calc_mode = MODE_OPER;
                        if (!calc_err)
                            apply_digit(k);
                    end
                    else if (k == KEY_CLEAR)
                    begin
                        shown_seg = 8'h00;
                        calc_mode = MODE_FIRST;
                    end
                    else if (is_op)
                    begin
                        shown_seg = SEG_TBL[SEG_DASH];
                        calc_op   = op_t'(2'(k - KEY_PLUS));
                        calc_mode = MODE_NEXT;
                    end
                    else if (k == KEY_EQUALS)
                        enter_show();
                default:
                    if (k == KEY_CLEAR)
                    begin
                        shown_seg = 8'h00;
                        calc_mode = MODE_FIRST;
                    end
                    else if (is_op)
                    begin
                        shown_seg = SEG_TBL[SEG_DASH];
                        calc_op   = op_t'(2'(k - KEY_PLUS));
                        calc_mode = MODE_NEXT;
                    end
            endcase
        end
        return shown_seg;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (seg_expect.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("segments error: unexpected transfer %02h", m_tdata);
            end
            else
            begin
                seg_want = seg_expect.pop_front();
                if (m_tdata !== seg_want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("segments error: expected %02h, got %02h",
                                 seg_want, m_tdata);
                end
            end
        end
        m_tready <= no_idle || ($urandom_range(99) >= 6);
    end

    task automatic send_item(input logic cmd_bit, input logic [3:0] k);
        if (!no_idle)
            while ($urandom_range(99) < 6)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd_bit;
        s_tdata  <= {4'b0000, k};
        do @(posedge clk); while (!s_tready);
        seg_expect.push_back(next_segments(cmd_bit, k));
    endtask

    task automatic send_ticks(input int n);
        for (int i = 0; i < n; i++)
            send_item(CMD_TICK, 4'($urandom_range(15)));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (seg_expect.size() != 0);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] val);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (addr == CFG_BLANK_AT)
            cfg_blank_at = val;
        else
            cfg_period = val;
    endtask

    task automatic test_basic_ops();
        logic [3:0] keys_a [] = '{KEY_PLUS, KEY_EQUALS, KEY_CLEAR, 4'd9, 4'd3, KEY_TIMES,
                                  KEY_PLUS, 4'd9, KEY_DIVIDE, 4'd2, KEY_EQUALS, 4'd9,
                                  KEY_EQUALS};
        logic [3:0] keys_b [] = '{KEY_MINUS, 4'd9, KEY_CLEAR};
        send_item(CMD_TICK, 4'd0);
        foreach (keys_a[i])
            send_item(CMD_KEY, keys_a[i]);
        send_item(CMD_TICK, 4'd15);
        foreach (keys_b[i])
            send_item(CMD_KEY, keys_b[i]);
    endtask

    // negative values, truncating divide, divide by zero, digits under error
    task automatic test_sign_and_error();
        logic [3:0] keys [] = '{4'd4, KEY_MINUS, 4'd7, KEY_EQUALS, KEY_DIVIDE, 4'd2,
                                KEY_TIMES, 4'd8, KEY_EQUALS, KEY_DIVIDE, 4'd0, KEY_PLUS,
                                4'd1, KEY_EQUALS, KEY_PLUS, KEY_CLEAR, 4'd0, KEY_CLEAR,
                                4'd0, KEY_EQUALS};
        foreach (keys[i])
            send_item(CMD_KEY, keys[i]);
    endtask

    task automatic test_wrap_arith();
        logic [3:0] keys [] = '{4'd9, KEY_TIMES, 4'd9, KEY_TIMES, 4'd9, KEY_TIMES, 4'd9,
                                KEY_TIMES, 4'd9, KEY_DIVIDE, 4'd1, KEY_EQUALS, KEY_CLEAR};
        foreach (keys[i])
            send_item(CMD_KEY, keys[i]);
    endtask

    task automatic test_blink_default();
        send_item(CMD_KEY, 4'd5);
        send_item(CMD_KEY, KEY_EQUALS);
        send_ticks(1001);
    endtask

    task automatic test_blink_small();
        write_reg(CFG_BLANK_AT, 16'd2);
        write_reg(CFG_BLINK_PERIOD, 16'd5);
        send_item(CMD_KEY, KEY_PLUS);
        send_item(CMD_KEY, 4'd3);
        send_item(CMD_KEY, KEY_EQUALS);
        send_ticks(12);
        // period before blank: stale saved byte comes back
        write_reg(CFG_BLANK_AT, 16'd3);
        write_reg(CFG_BLINK_PERIOD, 16'd2);
        send_item(CMD_KEY, KEY_MINUS);
        send_item(CMD_KEY, 4'd1);
        send_item(CMD_KEY, KEY_EQUALS);
        send_ticks(6);
        write_reg(CFG_BLANK_AT, 16'd1);
        write_reg(CFG_BLINK_PERIOD, 16'd1);
        send_ticks(4);
        send_item(CMD_KEY, KEY_CLEAR);
    endtask

    // period shrunk below the running count: display stays blank, no restore
    task automatic test_blink_wrap();
        write_reg(CFG_BLANK_AT, 16'd3);
        write_reg(CFG_BLINK_PERIOD, 16'hFFFF);
        send_item(CMD_KEY, 4'd6);
        send_item(CMD_KEY, KEY_EQUALS);
        send_ticks(8);
        write_reg(CFG_BLANK_AT, 16'd2);
        write_reg(CFG_BLINK_PERIOD, 16'd3);
        send_ticks(20);
        send_item(CMD_KEY, KEY_CLEAR);
    endtask

    task automatic test_random(input int n_items, input bit burst);
        int         roll;
        int         sent;
        logic       cmd_bit;
        logic [3:0] k;
        bit         noise;
        for (int r = 0; r < 2; r++)
        begin
            case ($urandom_range(3))
                0:       k = 4'd0;
                1:       k = 4'd1;
                default: k = 4'd2;
            endcase
            write_reg(r ? CFG_BLINK_PERIOD : CFG_BLANK_AT,
                      (k == 4'd0) ? 16'd1 : (k == 4'd1) ? 16'hFFFF
                                          : 16'($urandom_range(12, 1)));
        end
        no_idle = burst;
        sent = 0;
        while (sent < n_items)
        begin
            roll    = $urandom_range(99);
            cmd_bit = CMD_KEY;
            k       = 4'($urandom_range(9));
            noise   = 1'b0;
            if (roll < 8)
            begin
                cmd_bit = 1'($urandom_range(1));
                k       = 4'($urandom_range(15));
                noise   = 1'b1;
            end
            else
            begin
                case (calc_mode)
                    MODE_FIRST: ;
                    MODE_OPER:
                        if (roll < 70)
                            k = 4'(KEY_PLUS + $urandom_range(3));
                        else if (roll < 90)
                            k = KEY_EQUALS;
                        else
                            k = KEY_CLEAR;
                    MODE_NEXT:
                        if (roll >= 97)
                            k = KEY_CLEAR;
                        else if (roll >= 94)
                            k = KEY_EQUALS;
                        else if (roll >= 88)
                            k = 4'(KEY_PLUS + $urandom_range(3));
                    default:
                        if (roll < 80)
                        begin
                            cmd_bit = CMD_TICK;
                            k = 4'($urandom_range(15));
                        end
                        else if (roll < 94)
                            k = 4'(KEY_PLUS + $urandom_range(3));
                        else
                            k = KEY_CLEAR;
                endcase
            end
            send_item(cmd_bit, k);
            if (!noise)
                sent++;
        end
        drain_results();
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_ops();
        test_sign_and_error();
        test_wrap_arith();
        test_blink_default();
        test_blink_small();
        test_blink_wrap();
        test_random(80, 1'b1);
        test_random(50, 1'b0);
        test_random(50, 1'b0);
        test_random(50, 1'b0);
        drain_results();
        if (mismatches == 0 && seg_expect.size() == 0)
            $display("digit_calculator_with_blink_unit: match");
        else
            $display("digit_calculator_with_blink_unit: mismatch");
        $finish;
    end

endmodule

FILE: sim.f
hdl/dcb_pkg.sv
hdl/dcb_alu.sv
hdl/dcb_blink.sv
hdl/digit_calculator_with_blink_unit.sv
dv/digit_calculator_with_blink_unit_test.sv
